// ===== hdl/zzcd_pkg.sv =====
package zzcd_pkg;

    localparam int GRID_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF = 16;

    // fixed formats of the charge and scale registers
    localparam int CHARGE_FRAC  = 8;
    localparam int SCALE_FRAC   = 16;
    localparam int CHARGE_W     = 16;
    localparam int SCALE_W      = 32;
    localparam int WEIGHT_W     = 16;
    localparam int GROUP_W      = 2;
    localparam int INC_W        = 48;
    localparam int CFG_INDEX_W  = 3;

    localparam int N_TERMS      = 32;
    localparam int DENS_TERMS   = 8;
    localparam int SEG_TERMS    = 12;
    localparam int TERM_W       = 5;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CHARGE_0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHARGE_1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHARGE_2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHARGE_3 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE    = 3'd4;

    // quantity codes
    localparam logic [1:0] QTY_DENSITY = 2'd0;
    localparam logic [1:0] QTY_CUR_X   = 2'd1;
    localparam logic [1:0] QTY_CUR_Y   = 2'd2;
    localparam logic [1:0] QTY_CUR_Z   = 2'd3;

endpackage

// ===== hdl/zigzag_current_deposit_top.sv =====
// Zigzag charge-conserving current deposition, one particle in, 32 grid
// increments out.
// Input channel: in_valid / in_stall with pos_*, step_*, weight, group. A
// transfer happens on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with node_*, quantity, increment and
// last (set on the 32nd increment of a particle).
// Configuration: cfg_we, cfg_index, cfg_data; write only while idle.
// Throughput is set by the output channel moving one increment per cycle
// while out_stall is low. The next particle is taken in the cycle its
// predecessor's last term enters the pipeline, so particles run back to back.
// Terms run through a 7-stage pipeline (geometry, relay, weight select,
// flux partial products, flux sum, increment partial products, final sum).
// Reset clears the pipeline valid bits, the term sequencer and the
// configuration registers (charges 0, current scale 1.0).
// When out_stall is high with out_valid high the whole pipeline holds;
// nothing is lost or repeated, and the input stalls while a particle is held.
module zigzag_current_deposit_top
    import zzcd_pkg::*;
#(
    parameter int GRID_BITS = GRID_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [GRID_BITS+FRAC_BITS-1:0] pos_x,
    input  logic [GRID_BITS+FRAC_BITS-1:0] pos_y,
    input  logic [GRID_BITS+FRAC_BITS-1:0] pos_z,
    input  logic signed [FRAC_BITS:0]     step_x,
    input  logic signed [FRAC_BITS:0]     step_y,
    input  logic signed [FRAC_BITS:0]     step_z,
    input  logic [WEIGHT_W-1:0]           weight,
    input  logic [GROUP_W-1:0]            group,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [GRID_BITS-1:0]          node_x,
    output logic [GRID_BITS-1:0]          node_y,
    output logic [GRID_BITS-1:0]          node_z,
    output logic [1:0]                    quantity,
    output logic signed [INC_W-1:0]       increment,
    output logic                          last,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [SCALE_W-1:0]            cfg_data
);

    localparam int F    = FRAC_BITS;
    localparam int G    = GRID_BITS;
    localparam int PSW  = G + F;
    localparam int XW   = G + F + 2;
    localparam int CW   = G + 2;
    localparam int RW   = XW + 1;
    localparam int LW   = F + 4;
    localparam int WW   = F + 3;
    localparam int BW   = 2 * WW;
    localparam int QW   = 32;
    localparam int QSW  = 64;
    localparam int DAW  = F + 34;
    localparam int AW   = (DAW > INC_W) ? DAW : INC_W;
    localparam int AS   = AW / 2;
    localparam int PPW  = AW + BW + 1;
    localparam int FSW  = QSW + LW + 1;
    localparam int FLUX_SHIFT = CHARGE_FRAC + SCALE_FRAC + 1;
    localparam int DENS_SHIFT = CHARGE_FRAC + 2 * F;
    localparam int CUR_SHIFT  = 2 * F + 4;
    localparam logic [TERM_W-1:0] LAST_TERM = TERM_W'(N_TERMS - 1);
    localparam logic [TERM_W-1:0] SEG1_BASE = TERM_W'(DENS_TERMS + SEG_TERMS);
    localparam logic [TERM_W-1:0] SEG0_BASE = TERM_W'(DENS_TERMS);
    localparam logic [F:0]    ONE  = (F+1)'(1) << F;
    localparam logic [WW-1:0] ONE4 = WW'(1) << (F + 2);
    localparam logic signed [INC_W-1:0] INC_MAX = {1'b0, {(INC_W-1){1'b1}}};
    localparam logic signed [INC_W-1:0] INC_MIN = {1'b1, {(INC_W-1){1'b0}}};

    typedef struct packed {
        logic [G-1:0] nx;
        logic [G-1:0] ny;
        logic [G-1:0] nz;
        logic [1:0]   qty;
        logic         last;
        logic         dens;
    } meta_t;

    // configuration
    logic signed [CHARGE_W-1:0] charge_reg [4];
    logic signed [SCALE_W-1:0]  scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < 4; g++)
                charge_reg[g] <= '0;
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHARGE_0: charge_reg[0] <= cfg_data[CHARGE_W-1:0];
                CFG_CHARGE_1: charge_reg[1] <= cfg_data[CHARGE_W-1:0];
                CFG_CHARGE_2: charge_reg[2] <= cfg_data[CHARGE_W-1:0];
                CFG_CHARGE_3: charge_reg[3] <= cfg_data[CHARGE_W-1:0];
                CFG_SCALE:    scale_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // particle holding register and term sequencer
    logic                 busy_reg;
    logic [TERM_W-1:0]    k_reg;
    logic [PSW-1:0]       pos_reg [3];
    logic signed [F:0]    step_reg [3];
    logic [WEIGHT_W-1:0]  weight_reg;
    logic [GROUP_W-1:0]   group_reg;

    logic adv, issue, accept;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;

    assign adv      = !(v7_reg && out_stall);
    assign issue    = adv && busy_reg;
    assign in_stall = busy_reg && !(issue && k_reg == LAST_TERM);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end
            else if (issue)
            begin
                if (k_reg == LAST_TERM)
                    busy_reg <= 1'b0;
                k_reg <= k_reg + TERM_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg[0]  <= pos_x;
            pos_reg[1]  <= pos_y;
            pos_reg[2]  <= pos_z;
            step_reg[0] <= step_x;
            step_reg[1] <= step_y;
            step_reg[2] <= step_z;
            weight_reg  <= weight;
            group_reg   <= group;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= busy_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // stage 1: end position, midpoint sum, q
    logic signed [XW-1:0] x1_next [3];
    logic signed [XW-1:0] x2_next [3];
    logic signed [RW-1:0] mid_next [3];
    logic signed [QW:0]   q_full;

    logic signed [XW-1:0] s1_x1_reg [3];
    logic signed [XW-1:0] s1_x2_reg [3];
    logic signed [RW-1:0] s1_mid_reg [3];
    logic signed [QW-1:0] s1_q_reg;
    logic [TERM_W-1:0]    s1_k_reg;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            x1_next[a]  = $signed({2'b00, pos_reg[a]});
            x2_next[a]  = x1_next[a] + XW'(step_reg[a]);
            mid_next[a] = RW'(x1_next[a]) + RW'(x2_next[a]);
        end
        q_full = $signed({1'b0, weight_reg}) * charge_reg[group_reg];
    end

    // stage 2: relay point, q * scale, density q * w_z
    logic signed [CW-1:0]  c0_2 [3];
    logic signed [CW-1:0]  c1_2 [3];
    logic signed [RW-1:0]  r_next [3];
    logic signed [QSW-1:0] qs_next;
    logic [F:0]            wz_sel;
    logic signed [DAW-1:0] densa_next;

    logic signed [XW-1:0]  s2_x1_reg [3];
    logic signed [XW-1:0]  s2_x2_reg [3];
    logic signed [RW-1:0]  s2_r_reg [3];
    logic signed [QSW-1:0] s2_qs_reg;
    logic signed [AW-1:0]  s2_densa_reg;
    logic [TERM_W-1:0]     s2_k_reg;

    always_comb
    begin
        logic signed [CW-1:0] lo, hi;
        logic signed [RW-1:0] hi_s, lo1_s, m;
        for (int a = 0; a < 3; a++)
        begin
            c0_2[a] = s1_x1_reg[a][XW-1:F];
            c1_2[a] = s1_x2_reg[a][XW-1:F];
            lo = (c0_2[a] < c1_2[a]) ? c0_2[a] : c1_2[a];
            hi = (c0_2[a] < c1_2[a]) ? c1_2[a] : c0_2[a];
            hi_s  = $signed({hi, {(F+1){1'b0}}});
            lo1_s = $signed({CW'(lo + CW'(1)), {(F+1){1'b0}}});
            m = (s1_mid_reg[a] < hi_s) ? hi_s : s1_mid_reg[a];
            r_next[a] = (m < lo1_s) ? m : lo1_s;
        end
        qs_next = s1_q_reg * scale_reg;
        wz_sel = s1_k_reg[0] ? {1'b0, s1_x2_reg[2][F-1:0]}
                             : ONE - {1'b0, s1_x2_reg[2][F-1:0]};
        densa_next = s1_q_reg * $signed({1'b0, wz_sel});
    end

    // stage 3: segment weights, term decode, factor select
    logic [WW-1:0]        wq [2][3];
    logic [WW-1:0]        vq [2][3];
    logic signed [LW-1:0] len [2][3];
    logic [WW-1:0]        wd0 [3];
    logic [WW-1:0]        wd1 [3];
    logic [WW-1:0]        f1_next, f2_next;
    logic signed [LW-1:0] l_next;
    meta_t                m3_next;

    logic [WW-1:0]         s3_f1_reg, s3_f2_reg;
    logic signed [LW-1:0]  s3_l_reg;
    logic signed [QSW-1:0] s3_qs_reg;
    logic signed [AW-1:0]  s3_densa_reg;
    meta_t                 m3_reg;

    always_comb
    begin
        logic signed [CW-1:0]   c0, c1;
        logic signed [RW-1:0]   tx1, tx2;
        logic signed [RW:0]     wf0, wf1, lf0, lf1;
        logic                   seg;
        logic [TERM_W-1:0]      r;
        logic [1:0]             axis;
        logic [G-1:0]           ci, cj, ck;
        logic                   s0, s1;
        for (int a = 0; a < 3; a++)
        begin
            c0  = s2_x1_reg[a][XW-1:F];
            c1  = s2_x2_reg[a][XW-1:F];
            tx1 = $signed({s2_x1_reg[a], 1'b0});
            tx2 = $signed({s2_x2_reg[a], 1'b0});
            wf0 = (RW+1)'(tx1) + (RW+1)'(s2_r_reg[a]) - $signed({c0, {(F+2){1'b0}}});
            wf1 = (RW+1)'(tx2) + (RW+1)'(s2_r_reg[a]) - $signed({c1, {(F+2){1'b0}}});
            lf0 = (RW+1)'(s2_r_reg[a]) - (RW+1)'(tx1);
            lf1 = (RW+1)'(tx2) - (RW+1)'(s2_r_reg[a]);
            wq[0][a]  = wf0[WW-1:0];
            wq[1][a]  = wf1[WW-1:0];
            vq[0][a]  = ONE4 - wf0[WW-1:0];
            vq[1][a]  = ONE4 - wf1[WW-1:0];
            len[0][a] = lf0[LW-1:0];
            len[1][a] = lf1[LW-1:0];
            wd1[a] = WW'(s2_x2_reg[a][F-1:0]);
            wd0[a] = WW'(ONE - {1'b0, s2_x2_reg[a][F-1:0]});
        end

        seg  = (s2_k_reg >= SEG1_BASE);
        r    = s2_k_reg - (seg ? SEG1_BASE : SEG0_BASE);
        axis = r[3:2];
        s0   = r[0];
        s1   = r[1];
        ci   = seg ? s2_x2_reg[0][F+G-1:F] : s2_x1_reg[0][F+G-1:F];
        cj   = seg ? s2_x2_reg[1][F+G-1:F] : s2_x1_reg[1][F+G-1:F];
        ck   = seg ? s2_x2_reg[2][F+G-1:F] : s2_x1_reg[2][F+G-1:F];

        m3_next.last = (s2_k_reg == LAST_TERM);
        m3_next.dens = (s2_k_reg < SEG0_BASE);
        l_next = seg ? len[1][0] : len[0][0];

        if (m3_next.dens)
        begin
            // density at the end position, l m n from the term number
            f1_next = s2_k_reg[2] ? wd1[0] : wd0[0];
            f2_next = s2_k_reg[1] ? wd1[1] : wd0[1];
            m3_next.nx  = s2_x2_reg[0][F+G-1:F] + G'(s2_k_reg[2]);
            m3_next.ny  = s2_x2_reg[1][F+G-1:F] + G'(s2_k_reg[1]);
            m3_next.nz  = s2_x2_reg[2][F+G-1:F] + G'(s2_k_reg[0]);
            m3_next.qty = QTY_DENSITY;
        end
        else
        begin
            case (axis)
                2'd0:
                begin
                    f1_next = s0 ? wq[seg][1] : vq[seg][1];
                    f2_next = s1 ? wq[seg][2] : vq[seg][2];
                    l_next  = len[seg][0];
                    m3_next.nx  = ci;
                    m3_next.ny  = cj + G'(s0);
                    m3_next.nz  = ck + G'(s1);
                    m3_next.qty = QTY_CUR_X;
                end
                2'd1:
                begin
                    f1_next = s0 ? wq[seg][0] : vq[seg][0];
                    f2_next = s1 ? wq[seg][2] : vq[seg][2];
                    l_next  = len[seg][1];
                    m3_next.nx  = ci + G'(s0);
                    m3_next.ny  = cj;
                    m3_next.nz  = ck + G'(s1);
                    m3_next.qty = QTY_CUR_Y;
                end
                default:
                begin
                    f1_next = s0 ? wq[seg][0] : vq[seg][0];
                    f2_next = s1 ? wq[seg][1] : vq[seg][1];
                    l_next  = len[seg][2];
                    m3_next.nx  = ci + G'(s0);
                    m3_next.ny  = cj + G'(s1);
                    m3_next.nz  = ck;
                    m3_next.qty = QTY_CUR_Z;
                end
            endcase
        end
    end

    // stage 4: weight product and flux partial products
    logic [BW-1:0]           b_next;
    logic signed [QW+LW-1:0] fh_next;
    logic signed [QW+LW:0]   fl_next;

    logic [BW-1:0]           s4_b_reg;
    logic signed [QW+LW-1:0] s4_fh_reg;
    logic signed [QW+LW:0]   s4_fl_reg;
    logic signed [AW-1:0]    s4_densa_reg;
    meta_t                   m4_reg;

    always_comb
    begin
        b_next  = s3_f1_reg * s3_f2_reg;
        fh_next = $signed(s3_qs_reg[QSW-1:QW]) * s3_l_reg;
        fl_next = $signed({1'b0, s3_qs_reg[QW-1:0]}) * s3_l_reg;
    end

    // stage 5: flux sum, floor shift, saturate; pick the A operand
    logic signed [AW-1:0] a_next;

    logic [BW-1:0]        s5_b_reg;
    logic signed [AW-1:0] s5_a_reg;
    meta_t                m5_reg;

    always_comb
    begin
        logic signed [FSW-1:0]   fsum, fsh;
        logic signed [INC_W-1:0] flux;
        fsum = (FSW'(s4_fh_reg) <<< QW) + FSW'(s4_fl_reg);
        fsh  = fsum >>> FLUX_SHIFT;
        if ((&fsh[FSW-1:INC_W-1]) || !(|fsh[FSW-1:INC_W-1]))
            flux = fsh[INC_W-1:0];
        else
            flux = fsh[FSW-1] ? INC_MIN : INC_MAX;
        a_next = m4_reg.dens ? s4_densa_reg : AW'(flux);
    end

    // stage 6: increment partial products
    logic signed [AW-AS+BW:0] ph_next;
    logic signed [AS+BW+1:0]  pl_next;

    logic signed [AW-AS+BW:0] s6_ph_reg;
    logic signed [AS+BW+1:0]  s6_pl_reg;
    meta_t                    m6_reg;

    always_comb
    begin
        ph_next = $signed(s5_a_reg[AW-1:AS]) * $signed({1'b0, s5_b_reg});
        pl_next = $signed({1'b0, s5_a_reg[AS-1:0]}) * $signed({1'b0, s5_b_reg});
    end

    // stage 7: final sum, floor shift, saturate
    logic signed [INC_W-1:0] inc_next;
    logic signed [INC_W-1:0] inc_reg;
    meta_t                   m7_reg;

    always_comb
    begin
        logic signed [PPW-1:0] p, psh;
        p   = (PPW'(s6_ph_reg) <<< AS) + PPW'(s6_pl_reg);
        psh = m6_reg.dens ? (p >>> DENS_SHIFT) : (p >>> CUR_SHIFT);
        if ((&psh[PPW-1:INC_W-1]) || !(|psh[PPW-1:INC_W-1]))
            inc_next = psh[INC_W-1:0];
        else
            inc_next = psh[PPW-1] ? INC_MIN : INC_MAX;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                s1_x1_reg[a]  <= x1_next[a];
                s1_x2_reg[a]  <= x2_next[a];
                s1_mid_reg[a] <= mid_next[a];
                s2_x1_reg[a]  <= s1_x1_reg[a];
                s2_x2_reg[a]  <= s1_x2_reg[a];
                s2_r_reg[a]   <= r_next[a];
            end
            s1_q_reg     <= q_full[QW-1:0];
            s1_k_reg     <= k_reg;
            s2_qs_reg    <= qs_next;
            s2_densa_reg <= AW'(densa_next);
            s2_k_reg     <= s1_k_reg;
            s3_f1_reg    <= f1_next;
            s3_f2_reg    <= f2_next;
            s3_l_reg     <= l_next;
            s3_qs_reg    <= s2_qs_reg;
            s3_densa_reg <= s2_densa_reg;
            m3_reg       <= m3_next;
            s4_b_reg     <= b_next;
            s4_fh_reg    <= fh_next;
            s4_fl_reg    <= fl_next;
            s4_densa_reg <= s3_densa_reg;
            m4_reg       <= m3_reg;
            s5_b_reg     <= s4_b_reg;
            s5_a_reg     <= a_next;
            m5_reg       <= m4_reg;
            s6_ph_reg    <= ph_next;
            s6_pl_reg    <= pl_next;
            m6_reg       <= m5_reg;
            inc_reg      <= inc_next;
            m7_reg       <= m6_reg;
        end
    end

    assign out_valid = v7_reg;
    assign node_x    = m7_reg.nx;
    assign node_y    = m7_reg.ny;
    assign node_z    = m7_reg.nz;
    assign quantity  = m7_reg.qty;
    assign increment = inc_reg;
    assign last      = m7_reg.last;

endmodule

// ===== hdl/zzcd_checker.sv =====
module zzcd_sva
    import zzcd_pkg::*;
#(
    parameter int GRID_BITS = GRID_BITS_DEF
)
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [GRID_BITS-1:0]    node_x,
    input logic [1:0]              quantity,
    input logic signed [INC_W-1:0] increment,
    input logic                    last
);

    // a stalled transfer holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(increment)
                                   && $stable(node_x) && $stable(last))
    else $error("output changed while stalled");

    // the closing term of a particle is the last z-current deposit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> quantity == QTY_CUR_Z)
    else $error("last flag on a term other than z current");

    // density terms open a particle and never close it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && quantity == QTY_DENSITY |-> !last)
    else $error("last flag on a density term");

endmodule

bind zigzag_current_deposit_top zzcd_sva #(.GRID_BITS(GRID_BITS)) u_zzcd_checker (.*);
